/* hw/rtl/qmn_pkg.sv */
package qmn_pkg;

   localparam int unsigned COMPONENT_WIDTH_DEF = 32;
   localparam int unsigned FRACTION_BITS_DEF   = 30;

   // Pipeline control handed to the square root and division sections.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

/* hw/rtl/quaternion_multiply_normalize_top.sv */
// Normalized Hamilton product of two quaternions in signed fixed point.
// Input words (req_) carry both quaternions; each result word (rsp_) carries
// the unit product a*b and two flags. Every input word gives one result word.
// The product is formed exactly, shifted right by FRACTION_BITS and clamped,
// then divided by its magnitude (floor square root of the sum of squares).
// The pipeline registers products, pair sums, component sums, clamped
// components, squares, pair sums of squares and their total, then has one
// square root stage per root bit (COMPONENT_WIDTH + 1), one division stage
// per quotient bit (FRACTION_BITS + 1) and the output register.
// Throughput is one word per cycle: every stage takes a new word each cycle
// it advances. When the receiver holds rsp_tready low with a word waiting,
// the whole pipeline freezes and req_tready drops; no word is lost or repeated.
// Reset clears all valid bits; the block accepts a word on the next cycle.
// A product of zero magnitude returns all components zero with
// zero_magnitude set.
module quaternion_multiply_normalize_top import qmn_pkg::*; #(
   parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
   input  logic [8*COMPONENT_WIDTH-1:0]            req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // r_w, r_x, r_y, r_z, zero padding to whole bytes
   output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   // zero_magnitude, saturated
   output logic [1:0]                              rsp_tuser
);

   localparam int unsigned CW     = COMPONENT_WIDTH;
   localparam int unsigned FB     = FRACTION_BITS;
   localparam int unsigned PW     = 2 * CW;
   localparam int unsigned SW     = PW + 2;
   localparam int unsigned RW     = CW + 1;
   localparam int unsigned QW     = FB + 1;
   localparam int unsigned OUT_DW = ((4 * CW + 7) / 8) * 8;
   localparam int unsigned SIDE_W = 4 * CW + 5;
   localparam int unsigned CMPW   = ((QW > CW) ? QW : CW) + 1;

   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [PW:0]   half_type;
   typedef logic signed [SW-1:0] sum_type;

   localparam sum_type SUM_MAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam sum_type SUM_MIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic [CW-1:0]   COMP_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]   COMP_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CMPW-1:0] QHALF    = {{(CMPW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

   // Operand b index and subtract flag of each term; a index is the term slot modulo 4.
   localparam int unsigned B_IDX [16] = '{0, 1, 2, 3,  1, 0, 3, 2,
                                          2, 3, 0, 1,  3, 2, 1, 0};
   localparam logic        T_SUB [16] = '{1'b0, 1'b1, 1'b1, 1'b1,
                                          1'b0, 1'b0, 1'b0, 1'b1,
                                          1'b0, 1'b1, 1'b0, 1'b0,
                                          1'b0, 1'b0, 1'b1, 1'b0};

   logic                  adv;
   pipe_ctl_type          sqrt_ctl;
   pipe_ctl_type          div_ctl;

   logic signed [CW-1:0]  a_op [4];
   logic signed [CW-1:0]  b_op [4];

   logic [6:0]            vld_ff;
   prod_type              p1_ff  [16];
   half_type              h2_ff  [8];
   sum_type               s3_ff  [4];
   logic [CW-1:0]         c4_ff  [4];
   logic                  sat4_ff;
   logic [PW-2:0]         sq5_ff [4];
   logic [SIDE_W-1:0]     side5_ff;
   logic [PW-1:0]         pr6_ff [2];
   logic [SIDE_W-1:0]     side6_ff;
   logic [PW:0]           tot7_ff;
   logic [SIDE_W-1:0]     side7_ff;

   half_type              h2_in  [8];
   sum_type               sh4;
   logic [CW-1:0]         c4_in  [4];
   logic                  sat4_in;
   logic [SIDE_W-1:0]     side5_in;
   logic [PW-1:0]         sq5_full [4];

   logic                  sq_vld;
   logic [RW-1:0]         sq_root;
   logic [SIDE_W-1:0]     sq_side;

   logic                  dv_vld;
   logic [RW-1:0]         dv_m;
   logic [4*QW-1:0]       dv_q;
   logic [4:0]            dv_side;

   logic                  rsp_tvalid_ff;
   logic [OUT_DW-1:0]     rsp_tdata_ff;
   logic [1:0]            rsp_tuser_ff;
   logic [OUT_DW-1:0]     rsp_tdata_in;
   logic [1:0]            rsp_tuser_in;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         a_op[j] = req_tdata[j*CW +: CW];
         b_op[j] = req_tdata[(j+4)*CW +: CW];
      end
   end

   // Terms are signed, so each pair is added or subtracted after extension.
   always_comb begin
      half_type e0;
      half_type e1;
      for (int g = 0; g < 8; g++) begin
         e0 = half_type'(p1_ff[2*g]);
         e1 = half_type'(p1_ff[2*g+1]);
         h2_in[g] = (T_SUB[2*g]   ? -e0 : e0) + (T_SUB[2*g+1] ? -e1 : e1);
      end
   end

   always_comb begin
      sat4_in = 1'b0;
      sh4     = '0;
      for (int k = 0; k < 4; k++) begin
         sh4 = s3_ff[k] >>> FB;
         if (sh4 > SUM_MAX) begin
            c4_in[k] = COMP_MAX;
            sat4_in  = 1'b1;
         end else if (sh4 < SUM_MIN) begin
            c4_in[k] = COMP_MIN;
            sat4_in  = 1'b1;
         end else begin
            c4_in[k] = sh4[CW-1:0];
         end
      end
   end

   // Sideband from stage five on: magnitudes, signs and the clamp flag.
   always_comb begin
      logic [CW-1:0] mg;
      side5_in = '0;
      for (int k = 0; k < 4; k++) begin
         mg = c4_ff[k][CW-1] ? (~c4_ff[k] + {{(CW-1){1'b0}}, 1'b1}) : c4_ff[k];
         side5_in[k*CW +: CW] = mg;
         side5_in[4*CW + k]   = c4_ff[k][CW-1];
         sq5_full[k]          = mg * mg;
      end
      side5_in[4*CW + 4] = sat4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_tvalid};
      end
      if (adv) begin
         for (int t = 0; t < 16; t++) begin
            p1_ff[t] <= a_op[t % 4] * b_op[B_IDX[t]];
         end
         for (int g = 0; g < 8; g++) begin
            h2_ff[g] <= h2_in[g];
         end
         for (int k = 0; k < 4; k++) begin
            s3_ff[k] <= sum_type'(h2_ff[2*k]) + sum_type'(h2_ff[2*k+1]);
            c4_ff[k] <= c4_in[k];
            sq5_ff[k] <= sq5_full[k][PW-2:0];
         end
         sat4_ff  <= sat4_in;
         side5_ff <= side5_in;
         pr6_ff[0] <= {1'b0, sq5_ff[0]} + {1'b0, sq5_ff[1]};
         pr6_ff[1] <= {1'b0, sq5_ff[2]} + {1'b0, sq5_ff[3]};
         side6_ff <= side5_ff;
         tot7_ff  <= {1'b0, pr6_ff[0]} + {1'b0, pr6_ff[1]};
         side7_ff <= side6_ff;
      end
   end

   assign sqrt_ctl.advance = adv;
   assign sqrt_ctl.valid   = vld_ff[6];

   qmn_isqrt #(
      .ROOT_W (RW),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .n_in     ({1'b0, tot7_ff}),
      .side_in  (side7_ff),
      .vld_out  (sq_vld),
      .root_out (sq_root),
      .side_out (sq_side)
   );

   assign div_ctl.advance = adv;
   assign div_ctl.valid   = sq_vld;

   qmn_div #(
      .COMP_W (CW),
      .QUOT_W (QW),
      .SIDE_W (5)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .m_in     (sq_root),
      .mag_in   (sq_side[4*CW-1:0]),
      .side_in  (sq_side[4*CW +: 5]),
      .vld_out  (dv_vld),
      .m_out    (dv_m),
      .q_out    (dv_q),
      .side_out (dv_side)
   );

   // Restore the sign and clamp each quotient to the component range.
   always_comb begin
      logic [CMPW-1:0] qx;
      logic            zero;
      logic            fsat;
      zero = (dv_m == '0);
      fsat = 1'b0;
      rsp_tdata_in = '0;
      for (int k = 0; k < 4; k++) begin
         qx = {{(CMPW-QW){1'b0}}, dv_q[k*QW +: QW]};
         if (zero) begin
            rsp_tdata_in[k*CW +: CW] = '0;
         end else if (!dv_side[k]) begin
            if (qx > QHALF - {{(CMPW-1){1'b0}}, 1'b1}) begin
               rsp_tdata_in[k*CW +: CW] = COMP_MAX;
               fsat = 1'b1;
            end else begin
               rsp_tdata_in[k*CW +: CW] = qx[CW-1:0];
            end
         end else begin
            if (qx > QHALF) begin
               rsp_tdata_in[k*CW +: CW] = COMP_MIN;
               fsat = 1'b1;
            end else begin
               rsp_tdata_in[k*CW +: CW] = ~qx[CW-1:0] + {{(CW-1){1'b0}}, 1'b1};
            end
         end
      end
      rsp_tuser_in = {dv_side[4] | fsat, zero};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= dv_vld;
      end
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hw/rtl/qmn_isqrt.sv */
module qmn_isqrt import qmn_pkg::*; #(
   parameter int unsigned ROOT_W = COMPONENT_WIDTH_DEF + 1,
   parameter int unsigned SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pipe_ctl_type          ctl,
   input  logic [2*ROOT_W-1:0]   n_in,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  vld_out,
   output logic [ROOT_W-1:0]     root_out,
   output logic [SIDE_W-1:0]     side_out
);

   localparam int unsigned NW = 2 * ROOT_W;
   localparam int unsigned RB = ROOT_W + 2;

   logic [RB-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [NW-1:0]     n_ff    [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [ROOT_W-1:0] vld_ff;

   logic [RB-1:0]     rem_s   [ROOT_W];
   logic [ROOT_W-1:0] root_s  [ROOT_W];
   logic [NW-1:0]     n_s     [ROOT_W];
   logic [SIDE_W-1:0] side_s  [ROOT_W];
   logic [ROOT_W-1:0] vld_s;

   logic [RB-1:0]     rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   // One root bit per stage: bring down two radicand bits, try (root*4 + 1).
   always_comb begin
      logic [RB-1:0] cur;
      logic [RB:0]   diff;
      rem_s[0]  = '0;
      root_s[0] = '0;
      n_s[0]    = n_in;
      side_s[0] = side_in;
      vld_s[0]  = ctl.valid;
      for (int k = 1; k < ROOT_W; k++) begin
         rem_s[k]  = rem_ff[k-1];
         root_s[k] = root_ff[k-1];
         n_s[k]    = n_ff[k-1];
         side_s[k] = side_ff[k-1];
         vld_s[k]  = vld_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         cur  = {rem_s[k][RB-3:0], n_s[k][NW-1 -: 2]};
         diff = {1'b0, cur} - {1'b0, root_s[k], 2'b01};
         rem_in[k]  = diff[RB] ? cur : diff[RB-1:0];
         root_in[k] = {root_s[k][ROOT_W-2:0], ~diff[RB]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= vld_s;
      end
      if (ctl.advance) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            n_ff[k]    <= {n_s[k][NW-3:0], 2'b00};
            side_ff[k] <= side_s[k];
         end
      end
   end

   assign vld_out  = vld_ff[ROOT_W-1];
   assign root_out = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

/* hw/rtl/qmn_div.sv */
module qmn_div import qmn_pkg::*; #(
   parameter int unsigned COMP_W = COMPONENT_WIDTH_DEF,
   parameter int unsigned QUOT_W = FRACTION_BITS_DEF + 1,
   parameter int unsigned SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pipe_ctl_type          ctl,
   input  logic [COMP_W:0]       m_in,
   input  logic [4*COMP_W-1:0]   mag_in,    // lane 0 magnitude in the lowest bits
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  vld_out,
   output logic [COMP_W:0]       m_out,
   output logic [4*QUOT_W-1:0]   q_out,     // lane 0 quotient in the lowest bits
   output logic [SIDE_W-1:0]     side_out
);

   localparam int unsigned DB = COMP_W + 2;

   logic [DB-1:0]     rem_ff  [QUOT_W][4];
   logic [QUOT_W-1:0] q_ff    [QUOT_W][4];
   logic [COMP_W:0]   m_ff    [QUOT_W];
   logic [SIDE_W-1:0] side_ff [QUOT_W];
   logic [QUOT_W-1:0] vld_ff;

   logic [DB-1:0]     rem_s   [QUOT_W][4];
   logic [QUOT_W-1:0] q_s     [QUOT_W][4];
   logic [COMP_W:0]   m_s     [QUOT_W];
   logic [SIDE_W-1:0] side_s  [QUOT_W];
   logic [QUOT_W-1:0] vld_s;

   logic [DB-1:0]     rem_in  [QUOT_W][4];
   logic [QUOT_W-1:0] q_in    [QUOT_W][4];

   // Restoring division, one quotient bit per stage from the weight
   // 2^(QUOT_W-1) down. The quotient never exceeds 2^(QUOT_W-1) because the
   // magnitude is at least as large as any one component.
   always_comb begin
      logic [DB-1:0] cur;
      logic [DB:0]   diff;
      for (int l = 0; l < 4; l++) begin
         rem_s[0][l] = {2'b00, mag_in[l*COMP_W +: COMP_W]};
         q_s[0][l]   = '0;
      end
      m_s[0]    = m_in;
      side_s[0] = side_in;
      vld_s[0]  = ctl.valid;
      for (int k = 1; k < QUOT_W; k++) begin
         for (int l = 0; l < 4; l++) begin
            rem_s[k][l] = rem_ff[k-1][l];
            q_s[k][l]   = q_ff[k-1][l];
         end
         m_s[k]    = m_ff[k-1];
         side_s[k] = side_ff[k-1];
         vld_s[k]  = vld_ff[k-1];
      end
      for (int k = 0; k < QUOT_W; k++) begin
         for (int l = 0; l < 4; l++) begin
            cur  = (k == 0) ? rem_s[k][l] : {rem_s[k][l][DB-2:0], 1'b0};
            diff = {1'b0, cur} - {2'b00, m_s[k]};
            rem_in[k][l] = diff[DB] ? cur : diff[DB-1:0];
            q_in[k][l]   = {q_s[k][l][QUOT_W-2:0], ~diff[DB]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= vld_s;
      end
      if (ctl.advance) begin
         for (int k = 0; k < QUOT_W; k++) begin
            for (int l = 0; l < 4; l++) begin
               rem_ff[k][l] <= rem_in[k][l];
               q_ff[k][l]   <= q_in[k][l];
            end
            m_ff[k]    <= m_s[k];
            side_ff[k] <= side_s[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         q_out[l*QUOT_W +: QUOT_W] = q_ff[QUOT_W-1][l];
      end
   end

   assign vld_out  = vld_ff[QUOT_W-1];
   assign m_out    = m_ff[QUOT_W-1];
   assign side_out = side_ff[QUOT_W-1];

endmodule
